[rtl/pairwise_mean_variance_merge_top_defines.svh]
// Assertion macros shared by the merge block.
`ifndef PAIRWISE_MEAN_VARIANCE_MERGE_TOP_DEFINES_SVH
`define PAIRWISE_MEAN_VARIANCE_MERGE_TOP_DEFINES_SVH

// Clocked property, off while reset is asserted
`define PMVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same-cycle implication
`define PMVM_ASSERT_IMPL(lbl, cond, conseq, msg) \
    `PMVM_ASSERT(lbl, (cond) |-> (conseq), msg)

`endif

[rtl/pmvm_pkg.sv]
package pmvm_pkg;

    localparam int MEAN_FRAC_BITS = 16;
    localparam int N_W            = 33;   // count_a + count_b
    localparam int DIV_STEPS      = 64;   // quotient bits of the censum term
    localparam int MEAN_STEPS     = 32;   // quotient bits of the mean term
    localparam int XH_W           = 64 - MEAN_FRAC_BITS;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COUNT_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_B = 1'b1;

    typedef struct packed {
        logic signed [31:0] mean_a;
        logic signed [31:0] mean_b;
        logic [63:0]        censum_a;
        logic [63:0]        censum_b;
        logic               last_point;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] merged_mean;
        logic [63:0]        merged_censum;
        logic               both_empty;
        logic               saturated;
        logic               last_out;
    } t_out_beat;

    // Data that rides along the divider
    typedef struct packed {
        logic signed [31:0] mean_a;
        logic               neg;
        logic [63:0]        censum_a;
        logic [64:0]        censum_sum;
        logic               last;
        logic               empty;
        logic               sat_q;
    } t_side;

    // Partial remainders and dividend/quotient words of both divisions
    typedef struct packed {
        logic [N_W-1:0] rem_c;
        logic [63:0]    w_c;
        logic [N_W-1:0] rem_m;
        logic [31:0]    w_m;
    } t_div;

endpackage

[rtl/pmvm_in_if.sv]
interface pmvm_in_if;
    import pmvm_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pmvm_out_if.sv]
interface pmvm_out_if;
    import pmvm_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/pmvm_front.sv]
module pmvm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [31:0]               i_count_a,
    input  logic [31:0]               i_count_b,
    input  logic [pmvm_pkg::N_W-1:0]  i_n,
    input  logic                      i_v,
    input  pmvm_pkg::t_in_beat        i_beat,
    output logic                      o_rdy,
    output logic                      o_v,
    output pmvm_pkg::t_side           o_side,
    output pmvm_pkg::t_div            o_div,
    input  logic                      i_rdy_dn
);
    import pmvm_pkg::*;

    logic e1, e2, e3, e4, e5;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    t_side r1_side, r2_side, r3_side, r4_side, r5_side;
    logic [31:0]  r1_mag;
    logic [63:0]  r2_mprod, r2_ab, r2_mm;
    logic [63:0]  r3_mprod, r3_ll, r3_lh, r3_hl, r3_hh;
    logic [63:0]  r4_mprod;
    logic [127:0] r4_p;
    t_div         r5_div;

    logic signed [32:0] d;
    logic [32:0]        mag33;
    logic [XH_W-1:0]    xh;
    t_side              n_side1, n_side5;

    // Stage enables: a stage loads when empty or when it passes its beat on
    assign e5    = !r5_v || i_rdy_dn;
    assign e4    = !r4_v || e5;
    assign e3    = !r3_v || e4;
    assign e2    = !r2_v || e3;
    assign e1    = !r1_v || e2;
    assign o_rdy = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (e1) r1_v <= i_v;
            if (e2) r2_v <= r1_v;
            if (e3) r3_v <= r2_v;
            if (e4) r4_v <= r3_v;
            if (e5) r5_v <= r4_v;
        end
    end

    // Stage 1: difference of means, magnitude, sum of centered sums
    always_comb begin
        d     = {i_beat.mean_b[31], i_beat.mean_b} - {i_beat.mean_a[31], i_beat.mean_a};
        mag33 = d[32] ? 33'(-d) : 33'(d);
        n_side1.mean_a     = i_beat.mean_a;
        n_side1.neg        = d[32];
        n_side1.censum_a   = i_beat.censum_a;
        n_side1.censum_sum = {1'b0, i_beat.censum_a} + {1'b0, i_beat.censum_b};
        n_side1.last       = i_beat.last_point;
        n_side1.empty      = (i_n == '0);
        n_side1.sat_q      = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_side <= n_side1;
            r1_mag  <= mag33[31:0];
        end
    end

    // Stage 2: count_b*|d|, count_a*count_b, |d|^2
    always_ff @(posedge i_clk) begin
        if (e2) begin
            r2_side  <= r1_side;
            r2_mprod <= i_count_b * r1_mag;
            r2_ab    <= i_count_a * i_count_b;
            r2_mm    <= r1_mag * r1_mag;
        end
    end

    // Stage 3: 32x32 partial products of the 128-bit product
    always_ff @(posedge i_clk) begin
        if (e3) begin
            r3_side  <= r2_side;
            r3_mprod <= r2_mprod;
            r3_ll    <= r2_ab[31:0]  * r2_mm[31:0];
            r3_lh    <= r2_ab[31:0]  * r2_mm[63:32];
            r3_hl    <= r2_ab[63:32] * r2_mm[31:0];
            r3_hh    <= r2_ab[63:32] * r2_mm[63:32];
        end
    end

    // Stage 4: assemble the full product
    always_ff @(posedge i_clk) begin
        if (e4) begin
            r4_side  <= r3_side;
            r4_mprod <= r3_mprod;
            r4_p     <= {64'h0, r3_ll} + ({64'h0, r3_lh} << 32)
                      + ({64'h0, r3_hl} << 32) + {r3_hh, 64'h0};
        end
    end

    // Stage 5: drop fraction bits, check quotient overflow, seed dividers
    always_comb begin
        xh            = r4_p[127:64+MEAN_FRAC_BITS];
        n_side5       = r4_side;
        n_side5.sat_q = (xh >= XH_W'(i_n));
    end

    always_ff @(posedge i_clk) begin
        if (e5) begin
            r5_side      <= n_side5;
            r5_div.rem_c <= xh[N_W-1:0];
            r5_div.w_c   <= r4_p[63+MEAN_FRAC_BITS:MEAN_FRAC_BITS];
            r5_div.rem_m <= {1'b0, r4_mprod[63:32]};
            r5_div.w_m   <= r4_mprod[31:0];
        end
    end

    assign o_v    = r5_v;
    assign o_side = r5_side;
    assign o_div  = r5_div;

endmodule

[rtl/pmvm_divider.sv]
module pmvm_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pmvm_pkg::N_W-1:0]  i_n,
    input  logic                      i_v,
    input  pmvm_pkg::t_side           i_side,
    input  pmvm_pkg::t_div            i_div,
    output logic                      o_rdy,
    output logic                      o_v,
    output pmvm_pkg::t_side           o_side,
    output logic [63:0]               o_q_c,
    output logic [31:0]               o_q_m,
    input  logic                      i_rdy_dn
);
    import pmvm_pkg::*;

    logic  r_v    [DIV_STEPS];
    t_side r_side [DIV_STEPS];
    t_div  r_div  [DIV_STEPS];
    logic  en     [DIV_STEPS+1];

    assign en[DIV_STEPS] = i_rdy_dn;
    assign o_rdy         = en[0];

    // One restoring-division step per stage; the mean lane stops after its bits
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic          v_in;
        t_side         side_in;
        t_div          d_in, d_nx;
        logic [N_W:0]  t_c, t_m;
        logic          ge_c, ge_m;

        if (k == 0) begin : g_first
            assign v_in    = i_v;
            assign side_in = i_side;
            assign d_in    = i_div;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
            assign d_in    = r_div[k-1];
        end

        assign en[k] = !r_v[k] || en[k+1];

        always_comb begin
            t_c  = {d_in.rem_c, d_in.w_c[63]};
            ge_c = (t_c >= {1'b0, i_n});
            t_m  = {d_in.rem_m, d_in.w_m[31]};
            ge_m = (t_m >= {1'b0, i_n});
            d_nx = d_in;
            d_nx.rem_c = ge_c ? N_W'(t_c - {1'b0, i_n}) : t_c[N_W-1:0];
            d_nx.w_c   = {d_in.w_c[62:0], ge_c};
            if (k < MEAN_STEPS) begin
                d_nx.rem_m = ge_m ? N_W'(t_m - {1'b0, i_n}) : t_m[N_W-1:0];
                d_nx.w_m   = {d_in.w_m[30:0], ge_m};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_side[k] <= side_in;
                r_div[k]  <= d_nx;
            end
        end
    end

    assign o_v    = r_v[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];
    assign o_q_c  = r_div[DIV_STEPS-1].w_c;
    assign o_q_m  = r_div[DIV_STEPS-1].w_m;

endmodule

[rtl/pmvm_back.sv]
`include "pairwise_mean_variance_merge_top_defines.svh"

module pmvm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_v,
    input  pmvm_pkg::t_side  i_side,
    input  logic [63:0]      i_q_c,
    input  logic [31:0]      i_q_m,
    output logic             o_rdy,
    pmvm_out_if.source       o_out
);
    import pmvm_pkg::*;

    logic               r_valid;
    t_out_beat          r_out;
    logic               en;
    logic signed [32:0] mean_ext, mean33;
    logic [64:0]        sum2;
    logic               sat;
    t_out_beat          n_out;

    assign en    = !r_valid || o_out.ready;
    assign o_rdy = en;

    // Mean correction and saturating censum sum
    always_comb begin
        mean_ext = {i_side.mean_a[31], i_side.mean_a};
        mean33   = i_side.neg ? mean_ext - $signed({1'b0, i_q_m})
                              : mean_ext + $signed({1'b0, i_q_m});
        sum2     = {1'b0, i_side.censum_sum[63:0]} + {1'b0, i_q_c};
        sat      = i_side.censum_sum[64] || i_side.sat_q || sum2[64];
        n_out.last_out = i_side.last;
        if (i_side.empty) begin
            n_out.merged_mean   = i_side.mean_a;
            n_out.merged_censum = i_side.censum_a;
            n_out.both_empty    = 1'b1;
            n_out.saturated     = 1'b0;
        end else begin
            n_out.merged_mean   = mean33[31:0];
            n_out.merged_censum = sat ? '1 : sum2[63:0];
            n_out.both_empty    = 1'b0;
            n_out.saturated     = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_out;

    `PMVM_ASSERT_IMPL(a_empty_no_sat, r_valid && r_out.both_empty, !r_out.saturated, "empty merge flagged saturated")
    `PMVM_ASSERT_IMPL(a_sat_all_ones, r_valid && r_out.saturated, r_out.merged_censum == '1, "saturated censum not clipped")
    `PMVM_ASSERT_IMPL(a_valid_from_div, r_valid && !$past(r_valid), $past(i_v), "result appeared without a divider beat")

endmodule

[rtl/pairwise_mean_variance_merge_top.sv]
// Pairwise mean / centered-sum merge, one trace point per beat.
// Program count_a (index 0) and count_b (index 1) through the write port while
// the block is idle; both reset to zero. Each input beat carries the two means
// (signed Q16.16) and two centered sums (unsigned Q48.16) of one point; each
// output beat returns the merged mean, merged centered sum (saturating at
// all ones), the both_empty and saturated flags, and last_out.
// Stages: 70 registers lie between input and output: five for the
// difference, products, partial-product assembly and divider seeding,
// 64 restoring-division stages (one quotient bit each against
// n = count_a + count_b), and the output register.
// Throughput: one beat per cycle while the receiver accepts; every stage is a
// register with its own valid bit.
// Reset clears all valid bits and both counts; data registers are not reset.
// When the receiver stalls, the output register holds its beat and the stall
// moves back only through full stages, so bubbles still fill up; nothing is
// dropped or repeated.
module pairwise_mean_variance_merge_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pmvm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pmvm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    pmvm_in_if.sink                           i_in,
    pmvm_out_if.source                        o_out
);
    import pmvm_pkg::*;

    logic [31:0]    r_count_a, r_count_b;
    logic [N_W-1:0] n_sum;

    logic  f_v, f_rdy, dv_v, dv_rdy, bk_rdy;
    t_side f_side, dv_side;
    t_div  f_div;
    logic [63:0] q_c;
    logic [31:0] q_m;

    // Count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_a <= '0;
            r_count_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COUNT_A: r_count_a <= i_cfg_wdata;
                REG_COUNT_B: r_count_b <= i_cfg_wdata;
            endcase
        end
    end

    assign n_sum      = {1'b0, r_count_a} + {1'b0, r_count_b};
    assign i_in.ready = f_rdy;

    pmvm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_count_a (r_count_a),
        .i_count_b (r_count_b),
        .i_n       (n_sum),
        .i_v       (i_in.valid),
        .i_beat    (i_in.data),
        .o_rdy     (f_rdy),
        .o_v       (f_v),
        .o_side    (f_side),
        .o_div     (f_div),
        .i_rdy_dn  (dv_rdy)
    );

    pmvm_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n      (n_sum),
        .i_v      (f_v),
        .i_side   (f_side),
        .i_div    (f_div),
        .o_rdy    (dv_rdy),
        .o_v      (dv_v),
        .o_side   (dv_side),
        .o_q_c    (q_c),
        .o_q_m    (q_m),
        .i_rdy_dn (bk_rdy)
    );

    pmvm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (dv_v),
        .i_side  (dv_side),
        .i_q_c   (q_c),
        .i_q_m   (q_m),
        .o_rdy   (bk_rdy),
        .o_out   (o_out)
    );

endmodule
